// ----- rtl/core/ilp_pkg.sv -----
package ilp_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned HIST_W  = 32;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
  localparam logic [HIST_W-1:0]  HIST_MAX  = {HIST_W{1'b1}};

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  // One finished entry, as handed from the parser to the histogram stage
  typedef struct packed {
    logic [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]   item_position;
    logic               end_of_list;
    logic [LEN_W-1:0]   list_length;
    logic               value_overflow;
    logic               list_too_long;
  } entry_t;

endpackage

// ----- rtl/core/integer_list_text_parser_top.sv -----
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------------
// input    | in_valid_i / in_ready_o   | char_byte_i
// output   | out_valid_o / out_ready_i | item_value_o, item_position_o, end_of_list_o,
//          |                           | list_length_o, record_index_o,
//          |                           | value_overflow_o, list_too_long_o
//
// One byte per cycle unless a separator stalls; a separator's result is registered.
// The histogram row is read when a newline is taken and written back as its result
// leaves; the last write is forwarded, so back-to-back newlines need no bubble.
// Reset clears the parser state and the per-row written flags; no clearing pass.
// Digits and ignored bytes are taken even while a result is stalled; a separator
// waits until the output register is free or being emptied.
module integer_list_text_parser_top #(
  parameter int unsigned MAX_LIST = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  char_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ilp_pkg::VALUE_W-1:0] item_value_o,
  output logic [ilp_pkg::POS_W-1:0]   item_position_o,
  output logic                        end_of_list_o,
  output logic [ilp_pkg::LEN_W-1:0]   list_length_o,
  output logic [ilp_pkg::HIST_W-1:0]  record_index_o,
  output logic                        value_overflow_o,
  output logic                        list_too_long_o
);
  import ilp_pkg::*;

  logic   sep, accept, load;
  entry_t entry_new, entry_out;

  // A separator needs the output register; other bytes only touch the parser
  assign in_ready_o = !sep || !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && sep;

  ilp_parser #(
    .MAX_LIST (MAX_LIST)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_byte_i (char_byte_i),
    .accept_i    (accept),
    .sep_o       (sep),
    .entry_o     (entry_new)
  );

  ilp_hist #(
    .MAX_LIST (MAX_LIST)
  ) u_hist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .entry_i        (entry_new),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .entry_o        (entry_out),
    .record_index_o (record_index_o)
  );

  assign item_value_o     = entry_out.item_value;
  assign item_position_o  = entry_out.item_position;
  assign end_of_list_o    = entry_out.end_of_list;
  assign list_length_o    = entry_out.list_length;
  assign value_overflow_o = entry_out.value_overflow;
  assign list_too_long_o  = entry_out.list_too_long;

endmodule

// ----- rtl/core/ilp_ram.sv -----
module ilp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ilp_parser.sv -----
module ilp_parser #(
  parameter int unsigned MAX_LIST = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    char_byte_i,
  input  logic          accept_i,
  output logic          sep_o,
  output ilp_pkg::entry_t entry_o
);
  import ilp_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LIST + 1);
  localparam logic [CNT_W-1:0] LIST_MAX = CNT_W'(MAX_LIST);

  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               is_digit, is_comma, is_nl;
  logic [VALUE_W+3:0] acc_next;
  logic [CNT_W-1:0]   cnt_inc;
  logic               too_long;

  // Byte classification
  assign is_digit = (char_byte_i >= CHAR_ZERO) && (char_byte_i <= CHAR_NINE);
  assign is_comma = (char_byte_i == CHAR_COMMA);
  assign is_nl    = (char_byte_i == CHAR_NL);
  assign sep_o    = is_comma || is_nl;

  // value*10 + digit as two shifts and two adds
  assign acc_next = ({3'b000, acc_q, 1'b0} + {acc_q, 3'b000})
                  + (VALUE_W+4)'(char_byte_i - CHAR_ZERO);

  // Saturating entry count including the entry being ended
  assign cnt_inc  = (cnt_q >= CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
  assign too_long = cnt_inc > LIST_MAX;

  // Entry leaving with this separator
  always_comb begin
    entry_o.item_value     = acc_q;
    entry_o.item_position  = (cnt_q > CNT_W'(POS_MAX)) ? POS_MAX : cnt_q[POS_W-1:0];
    entry_o.end_of_list    = is_nl;
    entry_o.list_length    = '0;
    if (is_nl) begin
      entry_o.list_length  = LEN_W'(too_long ? LIST_MAX : cnt_inc);
    end
    entry_o.value_overflow = ovf_q;
    entry_o.list_too_long  = too_long;
  end

  // Next state
  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      if (is_digit) begin
        if (acc_next[VALUE_W+3:VALUE_W] != '0) begin
          acc_d = VALUE_MAX;
          ovf_d = 1'b1;
        end else begin
          acc_d = acc_next[VALUE_W-1:0];
        end
      end else if (sep_o) begin
        acc_d = '0;
        ovf_d = 1'b0;
        cnt_d = is_nl ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/ilp_hist.sv -----
module ilp_hist #(
  parameter int unsigned MAX_LIST = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  ilp_pkg::entry_t            entry_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output ilp_pkg::entry_t            entry_o,
  output logic [ilp_pkg::HIST_W-1:0] record_index_o
);
  import ilp_pkg::*;

  localparam int unsigned DEPTH = MAX_LIST + 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic                out_v_q, out_v_d;
  entry_t              ent_q;
  logic [DEPTH-1:0]    seen_q, seen_d;
  logic                byp_v_q;
  logic [IDX_W-1:0]    byp_idx_q;
  logic [HIST_W-1:0]   byp_data_q;

  logic [IDX_W-1:0]    idx;
  logic [HIST_W-1:0]   rdata, prior, wdata;
  logic                take, wr;

  assign idx   = ent_q.list_length[IDX_W-1:0];
  assign take  = out_v_q && out_ready_i;
  assign wr    = take && ent_q.end_of_list;
  assign wdata = (prior == HIST_MAX) ? prior : prior + 1'b1;

  // Histogram store, read when a newline transaction is loaded
  ilp_ram #(
    .WIDTH (HIST_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (idx),
    .wdata_i (wdata),
    .re_i    (load_i && entry_i.end_of_list),
    .raddr_i (entry_i.list_length[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Prior count: last write forwarded, unwritten rows read as zero
  always_comb begin
    priority if (byp_v_q && (byp_idx_q == idx)) begin
      prior = byp_data_q;
    end else if (seen_q[idx]) begin
      prior = rdata;
    end else begin
      prior = '0;
    end
  end

  assign record_index_o = ent_q.end_of_list ? prior : '0;
  assign out_valid_o    = out_v_q;
  assign entry_o        = ent_q;

  // Output occupancy and row-written flags
  always_comb begin
    out_v_d = out_v_q;
    if (take) begin
      out_v_d = 1'b0;
    end
    if (load_i) begin
      out_v_d = 1'b1;
    end
    seen_d = seen_q;
    if (wr) begin
      seen_d[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      seen_q  <= '0;
      byp_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      seen_q  <= seen_d;
      if (wr) begin
        byp_v_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= entry_i;
    end
    if (wr) begin
      byp_idx_q  <= idx;
      byp_data_q <= wdata;
    end
  end

endmodule
